// ===== hdl/bounding_sphere_from_vertices_top_defines.svh =====
// Assertion helpers for the RTL file that checks its own logic.
`ifndef BOUNDING_SPHERE_FROM_VERTICES_TOP_DEFINES_SVH
`define BOUNDING_SPHERE_FROM_VERTICES_TOP_DEFINES_SVH

// Check on every clock edge outside reset.
`define BSV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define BSV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/bsv_pkg.sv =====
`timescale 1ns / 1ps

package bsv_pkg;

  // Coordinate width (signed, 8 fraction bits)
  localparam int CB          = 16;
  localparam int COEFF_BITS  = 16;
  localparam int COEFF_FRAC  = 12;
  localparam int REG_BITS    = 64;

  // Transform datapath widths
  localparam int PROD_BITS   = CB + COEFF_BITS;
  localparam int SUM_BITS    = PROD_BITS + 2;
  localparam int SHIFT_BITS  = SUM_BITS - COEFF_FRAC;
  localparam int XLAT_BITS   = ((SHIFT_BITS > COEFF_BITS) ? SHIFT_BITS : COEFF_BITS) + 1;

  // Stream widths, padded to whole bytes
  localparam int IN_BITS     = ((3 * CB + 7) / 8) * 8;
  localparam int OUT_BITS    = ((4 * CB + 7) / 8) * 8;

  // Radius datapath widths
  localparam int SQ_BITS     = 2 * CB;
  localparam int ACC_BITS    = 2 * CB + 2;
  localparam int ROOT_BITS   = ACC_BITS / 2;
  localparam int REM_BITS    = ROOT_BITS + 3;
  localparam int STEP_BITS   = $clog2(ROOT_BITS + 1);

  // Box queue between front and back
  localparam int QDEPTH      = 2;
  localparam int QPTR_BITS   = $clog2(QDEPTH);
  localparam int QCNT_BITS   = $clog2(QDEPTH + 1);

  // Configuration register map
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_COL_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COL_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COL_Z = 2'd2;

  localparam logic [REG_BITS-1:0] RST_COL_X = 64'd4096;
  localparam logic [REG_BITS-1:0] RST_COL_Y = 64'd268435456;
  localparam logic [REG_BITS-1:0] RST_COL_Z = 64'd17592186044416;

  typedef logic signed [CB-1:0] coord_t;

  // Per-axis extremes of one finished model
  typedef struct packed {
    coord_t lo_x;
    coord_t lo_y;
    coord_t lo_z;
    coord_t hi_x;
    coord_t hi_y;
    coord_t hi_z;
  } box_t;

  typedef struct packed {
    logic push;
    box_t box;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    box_t box;
  } q_rd_t;

endpackage

// ===== hdl/bsv_front.sv =====
`timescale 1ns / 1ps

module bsv_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [bsv_pkg::IN_BITS-1:0]            s_tdata,
  input  logic                                   s_tlast,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [bsv_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [bsv_pkg::REG_BITS-1:0]           cfg_data,
  output bsv_pkg::q_wr_t                         q_wr,
  input  logic                                   q_full
);

  localparam logic signed [bsv_pkg::XLAT_BITS-1:0] SAT_MAX =
    bsv_pkg::XLAT_BITS'((64'sd1 <<< (bsv_pkg::CB - 1)) - 64'sd1);
  localparam logic signed [bsv_pkg::XLAT_BITS-1:0] SAT_MIN =
    bsv_pkg::XLAT_BITS'(-(64'sd1 <<< (bsv_pkg::CB - 1)));
  localparam bsv_pkg::coord_t COORD_MAX = bsv_pkg::CB'(SAT_MAX);
  localparam bsv_pkg::coord_t COORD_MIN = bsv_pkg::CB'(SAT_MIN);

  logic [bsv_pkg::REG_BITS-1:0]             col [3];
  logic signed [bsv_pkg::CB-1:0]            vin [3];
  logic signed [bsv_pkg::PROD_BITS-1:0]     prod [3][3];
  logic                                     p_valid;
  logic                                     p_last;
  logic signed [bsv_pkg::SUM_BITS-1:0]      sum [3];
  logic signed [bsv_pkg::SHIFT_BITS-1:0]    shifted [3];
  logic signed [bsv_pkg::XLAT_BITS-1:0]     xl [3];
  bsv_pkg::coord_t                          w_next [3];
  bsv_pkg::coord_t                          w [3];
  logic                                     w_valid;
  logic                                     w_last;
  bsv_pkg::coord_t                          lo [3];
  bsv_pkg::coord_t                          hi [3];
  bsv_pkg::coord_t                          lo_next [3];
  bsv_pkg::coord_t                          hi_next [3];
  logic                                     en;

  // Configuration writes; unknown index is dropped
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      col[0] <= bsv_pkg::RST_COL_X;
      col[1] <= bsv_pkg::RST_COL_Y;
      col[2] <= bsv_pkg::RST_COL_Z;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bsv_pkg::REG_COL_X: col[0] <= cfg_data;
        bsv_pkg::REG_COL_Y: col[1] <= cfg_data;
        bsv_pkg::REG_COL_Z: col[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stall the whole pipe only when a last vertex meets a full queue
  assign en       = !(w_valid && w_last && q_full);
  assign s_tready = en && !rst;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vin[k] = s_tdata[k*bsv_pkg::CB +: bsv_pkg::CB];
    end
  end

  // Stage 1: nine coefficient products
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_last <= s_tlast;
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 3; k++) begin
          prod[a][k] <= $signed(col[a][k*bsv_pkg::COEFF_BITS +: bsv_pkg::COEFF_BITS]) * vin[k];
        end
      end
    end
  end

  // Stage 2: sum, floor shift, translate, saturate
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum[a] = bsv_pkg::SUM_BITS'(prod[a][0]) + bsv_pkg::SUM_BITS'(prod[a][1])
             + bsv_pkg::SUM_BITS'(prod[a][2]);
      shifted[a] = bsv_pkg::SHIFT_BITS'(sum[a] >>> bsv_pkg::COEFF_FRAC);
      xl[a] = bsv_pkg::XLAT_BITS'(shifted[a])
            + bsv_pkg::XLAT_BITS'($signed(col[a][3*bsv_pkg::COEFF_BITS +: bsv_pkg::COEFF_BITS]));
      if (xl[a] > SAT_MAX) begin
        w_next[a] = COORD_MAX;
      end else if (xl[a] < SAT_MIN) begin
        w_next[a] = COORD_MIN;
      end else begin
        w_next[a] = bsv_pkg::CB'(xl[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
    end else if (en) begin
      w_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_last <= p_last;
      for (int a = 0; a < 3; a++) begin
        w[a] <= w_next[a];
      end
    end
  end

  // Stage 3: fold the vertex into the running box
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lo_next[a] = (w[a] < lo[a]) ? w[a] : lo[a];
      hi_next[a] = (w[a] > hi[a]) ? w[a] : hi[a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        lo[a] <= COORD_MAX;
        hi[a] <= COORD_MIN;
      end
    end else if (en && w_valid) begin
      for (int a = 0; a < 3; a++) begin
        lo[a] <= w_last ? COORD_MAX : lo_next[a];
        hi[a] <= w_last ? COORD_MIN : hi_next[a];
      end
    end
  end

  // Hand the finished box to the queue
  assign q_wr.push     = en && w_valid && w_last;
  assign q_wr.box.lo_x = lo_next[0];
  assign q_wr.box.lo_y = lo_next[1];
  assign q_wr.box.lo_z = lo_next[2];
  assign q_wr.box.hi_x = hi_next[0];
  assign q_wr.box.hi_y = hi_next[1];
  assign q_wr.box.hi_z = hi_next[2];

endmodule

// ===== hdl/bsv_queue.sv =====
`timescale 1ns / 1ps

module bsv_queue (
  input  logic           clk,
  input  logic           rst,
  input  bsv_pkg::q_wr_t q_wr,
  output logic           q_full,
  input  logic           q_pop,
  output bsv_pkg::q_rd_t q_rd
);

  bsv_pkg::box_t                   ent [bsv_pkg::QDEPTH];
  logic [bsv_pkg::QPTR_BITS-1:0]   wr_ptr;
  logic [bsv_pkg::QPTR_BITS-1:0]   rd_ptr;
  logic [bsv_pkg::QCNT_BITS-1:0]   cnt;
  logic                            do_push;
  logic                            do_pop;

  assign q_full     = (cnt == bsv_pkg::QCNT_BITS'(bsv_pkg::QDEPTH));
  assign q_rd.valid = (cnt != '0);
  assign q_rd.box   = ent[rd_ptr];
  assign do_push    = q_wr.push && !q_full;
  assign do_pop     = q_pop && q_rd.valid;

  // Store incoming box
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent[wr_ptr] <= q_wr.box;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == bsv_pkg::QPTR_BITS'(bsv_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == bsv_pkg::QPTR_BITS'(bsv_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/bsv_back.sv =====
`timescale 1ns / 1ps

module bsv_back (
  input  logic                          clk,
  input  logic                          rst,
  input  bsv_pkg::q_rd_t                q_rd,
  output logic                          q_pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bsv_pkg::OUT_BITS-1:0]  m_tdata
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SQUARE = 3'd1;
  localparam logic [2:0] ST_SUM    = 3'd2;
  localparam logic [2:0] ST_ROOT   = 3'd3;
  localparam logic [2:0] ST_SEND   = 3'd4;

  logic [2:0]                       state;
  bsv_pkg::coord_t                  box_lo [3];
  bsv_pkg::coord_t                  box_hi [3];
  logic signed [bsv_pkg::CB:0]      ext [3];
  logic [bsv_pkg::CB-1:0]           half_next [3];
  logic [bsv_pkg::CB-1:0]           half [3];
  logic [bsv_pkg::CB-1:0]           ctr [3];
  logic [bsv_pkg::SQ_BITS-1:0]      sq [3];
  logic [bsv_pkg::ACC_BITS-1:0]     acc;
  logic [bsv_pkg::REM_BITS-1:0]     rem;
  logic [bsv_pkg::REM_BITS-1:0]     rem_sh;
  logic [bsv_pkg::REM_BITS-1:0]     trial;
  logic [bsv_pkg::ROOT_BITS-1:0]    root;
  logic [bsv_pkg::STEP_BITS-1:0]    step;
  logic [bsv_pkg::CB-1:0]           rad;
  logic                             out_free;

  assign box_lo[0] = q_rd.box.lo_x;
  assign box_lo[1] = q_rd.box.lo_y;
  assign box_lo[2] = q_rd.box.lo_z;
  assign box_hi[0] = q_rd.box.hi_x;
  assign box_hi[1] = q_rd.box.hi_y;
  assign box_hi[2] = q_rd.box.hi_z;

  // Half extents, truncated; the box is never empty so extent is non-negative
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ext[a]       = (bsv_pkg::CB+1)'(box_hi[a]) - (bsv_pkg::CB+1)'(box_lo[a]);
      half_next[a] = ext[a][bsv_pkg::CB:1];
    end
  end

  // One root bit per step: bring down two bits, try to subtract
  assign rem_sh = {rem[bsv_pkg::REM_BITS-3:0], acc[bsv_pkg::ACC_BITS-1 -: 2]};
  assign trial  = bsv_pkg::REM_BITS'({root, 2'b01});
  assign rad    = root[bsv_pkg::CB] ? '1 : root[bsv_pkg::CB-1:0];

  assign q_pop    = (state == ST_IDLE) && q_rd.valid;
  assign out_free = !m_tvalid || m_tready;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE:   if (q_rd.valid) state <= ST_SQUARE;
        ST_SQUARE: state <= ST_SUM;
        ST_SUM:    state <= ST_ROOT;
        ST_ROOT:   if (step == bsv_pkg::STEP_BITS'(bsv_pkg::ROOT_BITS - 1)) state <= ST_SEND;
        ST_SEND:   if (out_free) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        for (int a = 0; a < 3; a++) begin
          half[a] <= half_next[a];
          ctr[a]  <= bsv_pkg::CB'(box_lo[a]) + half_next[a];
        end
      end
      ST_SQUARE: begin
        for (int a = 0; a < 3; a++) begin
          sq[a] <= half[a] * half[a];
        end
      end
      ST_SUM: begin
        acc  <= bsv_pkg::ACC_BITS'(sq[0]) + bsv_pkg::ACC_BITS'(sq[1])
              + bsv_pkg::ACC_BITS'(sq[2]);
        rem  <= '0;
        root <= '0;
        step <= '0;
      end
      ST_ROOT: begin
        acc  <= acc << 2;
        step <= step + 1'b1;
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[bsv_pkg::ROOT_BITS-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[bsv_pkg::ROOT_BITS-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // Output register: holds the sphere until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_SEND && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SEND && out_free) begin
      m_tdata <= bsv_pkg::OUT_BITS'({rad, ctr[2], ctr[1], ctr[0]});
    end
  end

endmodule

// ===== hdl/bounding_sphere_from_vertices_top.sv =====
`timescale 1ns / 1ps
// Bounding sphere of a vertex stream. Each vertex is put through the affine transform
// held in three 64-bit column registers, saturated to signed Q8.8 and folded into a
// per-axis min/max box; the beat with tlast closes the model and one sphere beat
// (centre = min + half extent, radius = truncated square root of the summed squared
// half extents) follows. Vertices are taken one per cycle through a three-stage
// transform pipe. Closed boxes wait in a two-entry queue while the radius unit works,
// one root bit per cycle over 17 steps, after squaring and summing the half extents.
// s_tready drops only when a last vertex finds that queue full. Configuration writes
// are accepted every cycle outside reset and belong in idle periods.
`include "bounding_sphere_from_vertices_top_defines.svh"

module bounding_sphere_from_vertices_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // vertex_x, vertex_y, vertex_z
  input  logic [bsv_pkg::IN_BITS-1:0]        s_tdata,
  // last_vertex
  input  logic                               s_tlast,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // center_x, center_y, center_z, sphere_radius
  output logic [bsv_pkg::OUT_BITS-1:0]       m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bsv_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [bsv_pkg::REG_BITS-1:0]       cfg_data
);

  bsv_pkg::q_wr_t q_wr;
  bsv_pkg::q_rd_t q_rd;
  logic           q_full;
  logic           q_pop;

  // Transform and box tracking
  bsv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_wr      (q_wr),
    .q_full    (q_full)
  );

  // Finished boxes
  bsv_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_rd   (q_rd)
  );

  // Centre and radius
  bsv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_rd     (q_rd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // A closed box never arrives at a full queue
  `BSV_ASSERT(a_no_overflow, q_wr.push |-> !q_full, "box pushed into full queue")
  // Input stalls only on a full queue
  `BSV_ASSERT(a_stall_cause, !s_tready |-> q_full, "input stalled without full queue")
  // The back end never pops an empty queue
  `BSV_ASSERT(a_pop_valid, q_pop |-> q_rd.valid, "pop from empty queue")
  // No sphere beat is offered right after reset
  `BSV_ASSERT_ALWAYS(a_rst_out, rst |=> !m_tvalid, "output valid after reset")

endmodule
